### hw/rtl/udp_packet_dispatch_classifier_core_assert.svh
// Assertion macros for the dispatch classifier. Both use the clk and rst of
// the module that expands them.
`ifndef UDP_PACKET_DISPATCH_CLASSIFIER_CORE_ASSERT_SVH
`define UDP_PACKET_DISPATCH_CLASSIFIER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define UDC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udc: same-cycle check failed");

`define UDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udc: next-cycle check failed");

`else

`define UDC_ASSERT_SAME(label, ante, cons)

`define UDC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hw/rtl/udc_pkg.sv
package udc_pkg;

  localparam int SLOT_COUNT = 256;

  localparam logic [6:0]  ETH_HDR_LEN = 7'd14;
  localparam logic [6:0]  OFFSET_MAX  = 7'd127;
  localparam logic [15:0] ETYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [3:0]  IP_VERSION4 = 4'd4;
  localparam logic [15:0] FRAG_MASK   = 16'h3fff;
  localparam logic [15:0] PORT_DNS    = 16'd53;
  localparam logic [15:0] PORT_DHCP_S = 16'd67;
  localparam logic [15:0] PORT_DHCP_C = 16'd68;

  // Byte offsets of the captured header fields
  localparam logic [6:0] OFF_ETYPE_HI = 7'd12;
  localparam logic [6:0] OFF_ETYPE_LO = 7'd13;
  localparam logic [6:0] OFF_VER_IHL  = 7'd14;
  localparam logic [6:0] OFF_FRAG_HI  = 7'd20;
  localparam logic [6:0] OFF_FRAG_LO  = 7'd21;
  localparam logic [6:0] OFF_PROTO    = 7'd23;

  typedef enum logic [1:0] {
    CFG_DNS_SLOT = 2'd0,
    CFG_UDP_SLOT = 2'd1,
    CFG_SERVER   = 2'd2,
    CFG_DISABLED = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    CLS_OTHER = 3'd0,
    CLS_ARP   = 3'd1,
    CLS_DNS   = 3'd2,
    CLS_DHCP  = 3'd3,
    CLS_UDP   = 3'd4
  } traffic_class_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic       dispatch;
    logic [7:0] slot;
    logic [2:0] traffic_class;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] dns_slot_number;
    logic [7:0] udp_slot_number;
    logic       server_role;
    logic [7:0] disabled_code;
  } cfg_t;

  // Header view including the byte being consumed; len is bytes seen so far
  typedef struct packed {
    logic [7:0]  len;
    logic [15:0] ether_type;
    logic [7:0]  ver_ihl;
    logic [7:0]  protocol;
    logic [15:0] frag;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } hdr_t;

endpackage

### hw/rtl/udc_hdr_parse.sv
module udc_hdr_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  udc_pkg::in_beat_t beat,
  output udc_pkg::hdr_t    hdr
);

  logic [6:0]  byte_offset;
  logic [15:0] ether_type_seen;
  logic [7:0]  version_and_length;
  logic [7:0]  ip_protocol_seen;
  logic [15:0] fragment_field;
  logic [15:0] source_port_seen;
  logic [15:0] dest_port_seen;

  logic [6:0] udp_at;
  logic       cap;
  logic [7:0] b;

  assign b      = beat.frame_byte;
  assign cap    = byte_offset != udc_pkg::OFFSET_MAX;
  // old IHL: the ver/IHL byte itself sits at or before the UDP window start
  assign udp_at = udc_pkg::ETH_HDR_LEN + {1'b0, version_and_length[3:0], 2'b00};

  always_comb begin
    hdr.len        = {1'b0, byte_offset} + 8'd1;
    hdr.ether_type = ether_type_seen;
    hdr.ver_ihl    = version_and_length;
    hdr.protocol   = ip_protocol_seen;
    hdr.frag       = fragment_field;
    hdr.src_port   = source_port_seen;
    hdr.dst_port   = dest_port_seen;
    if (cap) begin
      if (byte_offset == udc_pkg::OFF_ETYPE_HI) hdr.ether_type[15:8] = b;
      if (byte_offset == udc_pkg::OFF_ETYPE_LO) hdr.ether_type[7:0]  = b;
      if (byte_offset == udc_pkg::OFF_VER_IHL)  hdr.ver_ihl          = b;
      if (byte_offset == udc_pkg::OFF_FRAG_HI)  hdr.frag[15:8]       = b;
      if (byte_offset == udc_pkg::OFF_FRAG_LO)  hdr.frag[7:0]        = b;
      if (byte_offset == udc_pkg::OFF_PROTO)    hdr.protocol         = b;
      if (byte_offset > udc_pkg::OFF_VER_IHL) begin
        if (byte_offset == udp_at)         hdr.src_port[15:8] = b;
        if (byte_offset == udp_at + 7'd1)  hdr.src_port[7:0]  = b;
        if (byte_offset == udp_at + 7'd2)  hdr.dst_port[15:8] = b;
        if (byte_offset == udp_at + 7'd3)  hdr.dst_port[7:0]  = b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && beat.end_of_frame)) begin
      byte_offset        <= '0;
      ether_type_seen    <= '0;
      version_and_length <= '0;
      ip_protocol_seen   <= '0;
      fragment_field     <= '0;
      source_port_seen   <= '0;
      dest_port_seen     <= '0;
    end else if (step) begin
      byte_offset        <= cap ? byte_offset + 7'd1 : byte_offset;
      ether_type_seen    <= hdr.ether_type;
      version_and_length <= hdr.ver_ihl;
      ip_protocol_seen   <= hdr.protocol;
      fragment_field     <= hdr.frag;
      source_port_seen   <= hdr.src_port;
      dest_port_seen     <= hdr.dst_port;
    end
  end

endmodule

### hw/rtl/udc_verdict.sv
module udc_verdict (
  input  udc_pkg::hdr_t     hdr,
  input  udc_pkg::cfg_t     cfg,
  output udc_pkg::out_beat_t res
);

  logic [5:0] hl;
  logic       port_dns;
  logic       port_dhcp;
  logic       hdr_bad;
  logic [7:0] pick;
  logic       try_slot;
  logic       go;
  udc_pkg::traffic_class_t cls;

  assign hl = {hdr.ver_ihl[3:0], 2'b00};

  assign port_dns  = hdr.src_port == udc_pkg::PORT_DNS || hdr.dst_port == udc_pkg::PORT_DNS;
  assign port_dhcp = hdr.src_port == udc_pkg::PORT_DHCP_S ||
                     hdr.src_port == udc_pkg::PORT_DHCP_C ||
                     hdr.dst_port == udc_pkg::PORT_DHCP_S ||
                     hdr.dst_port == udc_pkg::PORT_DHCP_C;

  // IHL can't exceed 15 words, so only the lower bound needs checking
  assign hdr_bad = hdr.len < 8'd34 ||
                   hdr.ver_ihl[7:4] != udc_pkg::IP_VERSION4 ||
                   hdr.protocol != udc_pkg::PROTO_UDP ||
                   (hdr.frag & udc_pkg::FRAG_MASK) != 16'd0 ||
                   hl < 6'd20 ||
                   hdr.len < 8'd22 + {2'b00, hl};

  always_comb begin
    pick     = '0;
    try_slot = 1'b0;
    cls      = udc_pkg::CLS_OTHER;
    if (hdr.len < {1'b0, udc_pkg::ETH_HDR_LEN}) begin
      try_slot = 1'b0;
    end else if (hdr.ether_type == udc_pkg::ETYPE_ARP) begin
      pick     = cfg.dns_slot_number;
      try_slot = 1'b1;
      cls      = udc_pkg::CLS_ARP;
    end else if (hdr.ether_type != udc_pkg::ETYPE_IPV4 || hdr_bad) begin
      try_slot = 1'b0;
    end else if (port_dns) begin
      pick     = cfg.dns_slot_number;
      try_slot = 1'b1;
      cls      = udc_pkg::CLS_DNS;
    end else if (port_dhcp) begin
      pick     = cfg.dns_slot_number;
      try_slot = cfg.server_role;
      cls      = udc_pkg::CLS_DHCP;
    end else begin
      pick     = cfg.udp_slot_number;
      try_slot = 1'b1;
      cls      = udc_pkg::CLS_UDP;
    end
  end

  assign go = try_slot && pick != cfg.disabled_code &&
              {1'b0, pick} < 9'(udc_pkg::SLOT_COUNT);

  assign res = {go, (go ? pick : 8'd0), cls};

endmodule

### hw/rtl/udp_packet_dispatch_classifier_core.sv
// Frame classifier: takes one frame byte per beat (from the first Ethernet
// header byte, end_of_frame on the last) and returns one verdict beat per
// frame on out_beat. The last byte passes the input register, then its
// verdict is registered in the result register. Only the input and result
// registers sit in the path, so a byte is taken every cycle (one byte per
// clock) unless a last byte waits while the previous verdict is unaccepted,
// and a waiting verdict does not stall bytes of the next frame until that
// frame's own last byte. Slot registers are to be written by the user
// through the cfg port (always ready) only while no frame is in flight; the
// block does not enforce it. The offset saturates at 127; bytes from there on are not captured.
`include "udp_packet_dispatch_classifier_core_assert.svh"

module udp_packet_dispatch_classifier_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  udc_pkg::in_beat_t     in_beat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output udc_pkg::out_beat_t    out_beat,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  udc_pkg::cfg_index_t   cfg_index,
  input  logic [7:0]            cfg_data
);

  udc_pkg::cfg_t      cfg;
  udc_pkg::in_beat_t  in_q;
  logic               in_valid_q;
  udc_pkg::out_beat_t out_q;
  udc_pkg::hdr_t      hdr;
  udc_pkg::out_beat_t res;
  logic               adv;
  logic               out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dns_slot_number <= 8'd255;
      cfg.udp_slot_number <= 8'd255;
      cfg.server_role     <= 1'b0;
      cfg.disabled_code   <= 8'd255;
    end else if (cfg_valid) begin
      case (cfg_index)
        udc_pkg::CFG_DNS_SLOT: cfg.dns_slot_number <= cfg_data;
        udc_pkg::CFG_UDP_SLOT: cfg.udp_slot_number <= cfg_data;
        udc_pkg::CFG_SERVER:   cfg.server_role     <= cfg_data[0];
        udc_pkg::CFG_DISABLED: cfg.disabled_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  // non-final bytes never need the result register
  assign adv      = in_valid_q && (!in_q.end_of_frame || out_free);
  assign in_ready = !in_valid_q || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_beat;
    end
  end

  udc_hdr_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .beat (in_q),
    .hdr  (hdr)
  );

  udc_verdict u_verdict (
    .hdr (hdr),
    .cfg (cfg),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && in_q.end_of_frame) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_q.end_of_frame) begin
      out_q <= res;
    end
  end

  assign out_beat = out_q;

  `UDC_ASSERT_NEXT(a_last_gives_verdict, adv && in_q.end_of_frame, out_valid)
  `UDC_ASSERT_SAME(a_no_disabled_slot, out_valid && out_beat.dispatch,
                   out_beat.slot != cfg.disabled_code)
  `UDC_ASSERT_SAME(a_dispatch_has_class, out_valid && out_beat.dispatch,
                   out_beat.traffic_class != udc_pkg::CLS_OTHER)
  `UDC_ASSERT_SAME(a_pass_slot_zero, out_valid && !out_beat.dispatch,
                   out_beat.slot == 8'd0)
  `UDC_ASSERT_SAME(a_no_overwrite, out_valid && !out_ready,
                   !(adv && in_q.end_of_frame))

endmodule
